>>> design/simplex_tableau_solver_macros.svh
// assertion helpers
`ifndef SIMPLEX_TABLEAU_SOLVER_MACROS_SVH
`define SIMPLEX_TABLEAU_SOLVER_MACROS_SVH
`define STS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("label failed");
`define STS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("label failed");
`endif

>>> design/sts_pkg.sv
package sts_pkg;
   localparam int unsigned DataW = 32;
   localparam logic [1:0] StatusOptimal   = 2'd0;
   localparam logic [1:0] StatusLimit     = 2'd1;
   localparam logic [1:0] StatusNegative  = 2'd2;
   localparam logic [1:0] StatusUnbounded = 2'd3;
   localparam logic [1:0] CsrSeekMode  = 2'd0;
   localparam logic [1:0] CsrIterLimit = 2'd1;
   localparam logic [1:0] CsrRowsUsed  = 2'd2;
   localparam logic [1:0] CsrColsUsed  = 2'd3;
   localparam logic FuncLoad = 1'b0;
   localparam logic FuncRun  = 1'b1;

   typedef struct packed {
      logic               func;
      logic [4:0]         cell_row;
      logic [4:0]         cell_col;
      logic signed [31:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [4:0]         result_index;
      logic signed [31:0] result_value;
      logic [15:0]        iterations_done;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // saturate a 64 bit value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

>>> design/sts_ram.sv
module sts_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 289
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> design/sts_div.sv
// signed 64 / 33 bit divider, one quotient bit per cycle, truncating toward zero
module sts_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [32:0] divisor,
   output logic               done,
   output logic signed [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] abs_n, abs_d;

   assign abs_n = dividend[63] ? 64'(-dividend) : 64'(dividend);
   assign abs_d = divisor[32] ? 64'(-64'(divisor)) : 64'(64'(divisor));

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], quo_ff[63]};
      if (start) begin
         quo_in  = abs_n;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         rem_in = trial;
         if (trial >= {1'b0, den_ff}) begin
            rem_in    = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= abs_d;
         neg_ff <= dividend[63] ^ divisor[32];
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 64'(-quo_ff) : 64'(quo_ff);
endmodule

>>> design/simplex_tableau_solver.sv
// Simplex tableau solver, signed Q16.16, modified Jordan exchange.
// req_ channel: func 0 writes one tableau cell (row 0 objective, column 0
// right side); out-of-range cells are dropped. A load gives no result.
// func 1 runs the solver on the loaded tableau.
// csr_ channel: writes seek_mode, iteration_limit, rows_used, cols_used;
// write only while no run is in progress.
// A run reads every right side, prepares the objective row, then
// for each pivot scans the objective row (n reads), the pivot column with
// ratio test (two reads per row, two 32x32 products per candidate row) and
// rewrites all (m+1)(n+1) cells. Every rewritten cell waits on the shared
// bit-serial divider; the tableau memory has a single read port.
// Results: n+1 beats on rsp_ (n the clamped cols_used), index 0 the objective,
// last flagged.
// A stalled receiver holds the beat in the output register; nothing is lost.
// Reset clears the basis map, iteration count and registers (0,100,16,16);
// the tableau memory is not cleared and must be loaded before a run.
module simplex_tableau_solver
   import sts_pkg::*;
#(
   parameter int unsigned MAX_ROWS = 16,
   parameter int unsigned MAX_COLS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);
`include "simplex_tableau_solver_macros.svh"
   localparam int unsigned Stride = MAX_COLS + 1;
   localparam int unsigned Depth  = (MAX_ROWS + 1) * Stride;
   localparam int unsigned AW     = $clog2(Depth);
   localparam int unsigned RW     = $clog2(MAX_ROWS + 1);
   localparam int unsigned CW     = $clog2(MAX_COLS + 1);
   localparam int unsigned BW     = $clog2(MAX_COLS);

   typedef enum logic [4:0] {
      S_IDLE, S_NEG_RD, S_NEG_CHK, S_OBJ_W, S_OBJ_RD, S_OBJ_NEG,
      S_LIM, S_COL_RD, S_COL_CHK, S_ROW_RDA, S_ROW_RDB, S_ROW_CHK,
      S_RAT_MUL, S_RAT_CMP, S_PV_RD, S_PV_GET, S_C_RDA, S_C_RDB, S_C_RDC,
      S_C_MUL, S_C_DIV, S_C_WR, S_OUT_RD, S_OUT_GET, S_OUT_SEND
   } state_type;

   state_type state_ff;
   logic        seek_ff;
   logic [15:0] limit_ff, iters_ff;
   logic [4:0]  rows_ff, cols_ff;
   logic [RW-1:0] m_ff, i_ff, pr_ff;
   logic [CW-1:0] n_ff, j_ff, pc_ff;
   logic [1:0]  status_ff;
   logic signed [31:0] best_ff, a_ff, b_ff, pa_ff, pb_ff, piv_ff, t_ff;
   logic signed [63:0] p1_ff, p2_ff;
   logic [RW-1:0] basis_ff [MAX_COLS];
   logic [4:0]  idx_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]   wdata, rdata;
   logic          div_start, div_done;
   logic signed [63:0] div_n, div_q;
   logic signed [32:0] div_d;
   logic [RW-1:0] m_eff;
   logic [CW-1:0] n_eff;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(r * Stride + c);
   endfunction

   always_comb begin
      m_eff = (rows_ff == 5'd0) ? RW'(1) :
              (32'(rows_ff) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_ff);
      n_eff = (cols_ff == 5'd0) ? CW'(1) :
              (32'(cols_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_ff);
   end

   sts_ram #(.Width(DataW), .Depth(Depth)) u_tab (
      .clock, .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   sts_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(div_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // read address, write port and divider start by state
   always_comb begin
      raddr = '0;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      div_start = 1'b0;
      div_n = '0;
      div_d = 33'(piv_ff);
      case (state_ff)
         S_IDLE: begin
            we = req_valid && req_data.func == FuncLoad &&
                 32'(req_data.cell_row) <= MAX_ROWS && 32'(req_data.cell_col) <= MAX_COLS;
            waddr = addr_of(RW'(req_data.cell_row), CW'(req_data.cell_col));
            wdata = req_data.cell_value;
         end
         S_NEG_RD:  raddr = addr_of(i_ff, '0);
         S_OBJ_W: begin
            // tableau stays untouched when a right side is negative
            we = (status_ff != StatusNegative); waddr = '0; wdata = '0;
         end
         S_OBJ_RD:  raddr = addr_of('0, j_ff);
         S_OBJ_NEG: begin
            we = 1'b1; waddr = addr_of('0, j_ff);
            wdata = sat32(-64'(signed'(rdata)));
         end
         S_COL_RD:  raddr = addr_of('0, j_ff);
         S_ROW_RDA: raddr = addr_of(i_ff, pc_ff);
         S_ROW_RDB: raddr = addr_of(i_ff, '0);
         S_PV_RD:   raddr = addr_of(pr_ff, pc_ff);
         S_C_RDA:   raddr = addr_of(i_ff, pc_ff);
         S_C_RDB:   raddr = addr_of(pr_ff, j_ff);
         S_C_RDC:   raddr = addr_of(i_ff, j_ff);
         S_C_MUL: begin
            div_start = 1'b1;
            if (i_ff == pr_ff && j_ff == pc_ff) div_n = 64'sh1_0000_0000;
            else if (i_ff == pr_ff) div_n = 64'(signed'(b_ff)) <<< 16;
            else if (j_ff == pc_ff) div_n = -(64'(signed'(a_ff)) <<< 16);
            else div_n = p1_ff;
         end
         S_C_WR: begin
            we = 1'b1; waddr = addr_of(i_ff, j_ff);
            if (i_ff == pr_ff || j_ff == pc_ff) wdata = sat32(div_q);
            else wdata = sat32(64'(signed'(t_ff)) - div_q);
         end
         S_OUT_RD, S_OUT_GET:
            raddr = addr_of((idx_ff == 5'd0) ? RW'(0) : basis_ff[BW'(idx_ff - 5'd1)], '0);
         default: ;
      endcase
   end

   // cells are updated in place: pivot row and column last so that other cells see
   // old values. order: rows i != pr, columns j != pc; then column pc; then row pr.
   // pass 0: interior, pass 1: column pc (i != pr), pass 2: row pr (all j)
   logic [1:0] pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seek_ff <= 1'b0;
         limit_ff <= 16'd100;
         rows_ff <= 5'd16;
         cols_ff <= 5'd16;
         iters_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_COLS; k++) basis_ff[k] <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CsrSeekMode:  seek_ff  <= csr_wdata[0];
               CsrIterLimit: limit_ff <= csr_wdata[15:0];
               CsrRowsUsed:  rows_ff  <= csr_wdata[4:0];
               CsrColsUsed:  cols_ff  <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid && req_data.func == FuncRun) begin
               m_ff <= m_eff; n_ff <= n_eff;
               for (int k = 0; k < MAX_COLS; k++) basis_ff[k] <= '0;
               status_ff <= StatusOptimal;
               iters_ff <= '0;
               i_ff <= RW'(1);
               state_ff <= S_NEG_RD;
            end
            S_NEG_RD: state_ff <= S_NEG_CHK;
            S_NEG_CHK: begin
               if (rdata[31]) status_ff <= StatusNegative;
               if (i_ff == m_ff) state_ff <= S_OBJ_W;
               else begin
                  i_ff <= i_ff + RW'(1);
                  state_ff <= S_NEG_RD;
               end
            end
            S_OBJ_W: begin
               j_ff <= CW'(1);
               if (status_ff == StatusNegative) begin
                  idx_ff <= '0; state_ff <= S_OUT_RD;
               end else if (seek_ff) state_ff <= S_LIM;
               else state_ff <= S_OBJ_RD;
            end
            S_OBJ_RD: state_ff <= S_OBJ_NEG;
            S_OBJ_NEG: begin
               if (j_ff == n_ff) state_ff <= S_LIM;
               else begin
                  j_ff <= j_ff + CW'(1); state_ff <= S_OBJ_RD;
               end
            end
            S_LIM: begin
               j_ff <= CW'(1); pc_ff <= '0; best_ff <= '0;
               if (iters_ff >= limit_ff) begin
                  status_ff <= StatusLimit; idx_ff <= '0; state_ff <= S_OUT_RD;
               end else state_ff <= S_COL_RD;
            end
            S_COL_RD: state_ff <= S_COL_CHK;
            S_COL_CHK: begin
               if ($signed(rdata) > best_ff) begin
                  best_ff <= rdata; pc_ff <= j_ff;
               end
               if (j_ff == n_ff) begin
                  i_ff <= RW'(1); pr_ff <= '0;
                  if ($signed(rdata) > best_ff) state_ff <= S_ROW_RDA;
                  else if (pc_ff == '0) begin
                     status_ff <= StatusOptimal; idx_ff <= '0; state_ff <= S_OUT_RD;
                  end else state_ff <= S_ROW_RDA;
               end else begin
                  j_ff <= j_ff + CW'(1); state_ff <= S_COL_RD;
               end
            end
            S_ROW_RDA: state_ff <= S_ROW_RDB;
            S_ROW_RDB: begin
               a_ff <= rdata; state_ff <= S_ROW_CHK;
            end
            S_ROW_CHK: begin
               b_ff <= rdata;
               if (a_ff <= 0 || rdata[31]) state_ff <= S_RAT_CMP;
               else state_ff <= S_RAT_MUL;
            end
            S_RAT_MUL: begin
               p1_ff <= 64'(b_ff) * 64'(pa_ff);
               p2_ff <= 64'(pb_ff) * 64'(a_ff);
               state_ff <= S_RAT_CMP;
            end
            S_RAT_CMP: begin
               if (!(a_ff <= 0 || b_ff[31]) && (pr_ff == '0 || p1_ff < p2_ff)) begin
                  pr_ff <= i_ff; pa_ff <= a_ff; pb_ff <= b_ff;
               end
               if (i_ff == m_ff) begin
                  state_ff <= S_PV_RD;
               end else begin
                  i_ff <= i_ff + RW'(1); state_ff <= S_ROW_RDA;
               end
            end
            S_PV_RD: begin
               if (pr_ff == '0) begin
                  status_ff <= StatusUnbounded; idx_ff <= '0; state_ff <= S_OUT_RD;
               end else begin
                  // entering variable takes the row, any older owner of it drops out
                  for (int k = 0; k < MAX_COLS; k++)
                     if (k == int'(pc_ff) - 1) basis_ff[k] <= pr_ff;
                     else if (basis_ff[k] == pr_ff) basis_ff[k] <= '0;
                  state_ff <= S_PV_GET;
               end
            end
            S_PV_GET: begin
               piv_ff <= rdata;
               pass_ff <= 2'd0;
               i_ff <= (pr_ff == '0) ? RW'(1) : '0;
               j_ff <= (pc_ff == '0) ? CW'(1) : '0;
               state_ff <= S_C_RDA;
            end
            S_C_RDA: state_ff <= S_C_RDB;
            S_C_RDB: begin
               a_ff <= rdata; state_ff <= S_C_RDC;
            end
            S_C_RDC: begin
               b_ff <= rdata; state_ff <= S_C_MUL;
            end
            S_C_MUL: begin
               t_ff <= rdata;
               state_ff <= S_C_DIV;
            end
            S_C_DIV: if (div_done) state_ff <= S_C_WR;
            S_C_WR: begin
               state_ff <= S_C_RDA;
               case (pass_ff)
                  2'd0: begin
                     if (j_ff == n_ff || (j_ff + CW'(1) == pc_ff && pc_ff == n_ff)) begin
                        if (i_ff == m_ff || (i_ff + RW'(1) == pr_ff && pr_ff == m_ff)) begin
                           pass_ff <= 2'd1; j_ff <= pc_ff;
                           i_ff <= (pr_ff == '0) ? RW'(1) : '0;
                        end else begin
                           j_ff <= (pc_ff == '0) ? CW'(1) : '0;
                           if (i_ff + RW'(1) == pr_ff) i_ff <= i_ff + RW'(2);
                           else i_ff <= i_ff + RW'(1);
                        end
                     end else if (j_ff + CW'(1) == pc_ff) j_ff <= j_ff + CW'(2);
                     else j_ff <= j_ff + CW'(1);
                  end
                  2'd1: begin
                     if (i_ff == m_ff || (i_ff + RW'(1) == pr_ff && pr_ff == m_ff)) begin
                        pass_ff <= 2'd2; i_ff <= pr_ff;
                        j_ff <= (pc_ff == '0) ? CW'(1) : '0;
                     end else if (i_ff + RW'(1) == pr_ff) i_ff <= i_ff + RW'(2);
                     else i_ff <= i_ff + RW'(1);
                  end
                  default: begin
                     if (j_ff == pc_ff) begin
                        iters_ff <= iters_ff + 16'd1; state_ff <= S_LIM;
                     end else if (j_ff == n_ff || (j_ff + CW'(1) == pc_ff && pc_ff == n_ff))
                        j_ff <= pc_ff;
                     else if (j_ff + CW'(1) == pc_ff) j_ff <= j_ff + CW'(2);
                     else j_ff <= j_ff + CW'(1);
                  end
               endcase
            end
            S_OUT_RD: if (!rsp_valid_ff || rsp_ready) state_ff <= S_OUT_GET;
            S_OUT_GET: state_ff <= S_OUT_SEND;
            S_OUT_SEND: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.result_index <= idx_ff;
               rsp_ff.iterations_done <= iters_ff;
               rsp_ff.status <= status_ff;
               rsp_ff.last <= (idx_ff == 5'(n_ff));
               if (status_ff == StatusNegative) rsp_ff.result_value <= '0;
               else if (idx_ff == 5'd0)
                  rsp_ff.result_value <= seek_ff ? sat32(-64'(signed'(rdata))) : rdata;
               else if (basis_ff[BW'(idx_ff - 5'd1)] == '0) rsp_ff.result_value <= '0;
               else rsp_ff.result_value <= rdata;
               if (idx_ff == 5'(n_ff)) state_ff <= S_IDLE;
               else begin
                  idx_ff <= idx_ff + 5'd1; state_ff <= S_OUT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // interior product held for the divider
         if (state_ff == S_C_RDC) p1_ff <= 64'(a_ff) * 64'(signed'(rdata));
      end
   end

   `STS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `STS_ASSERT_IMP(a_busy, clock, reset, state_ff != S_IDLE, !req_ready)
   `STS_ASSERT_IMP(a_iters, clock, reset, rsp_valid, rsp_data.iterations_done <= limit_ff)
endmodule
